/* hdl/rfdx_pkg.sv */
package rfdx_pkg;

  localparam int unsigned MAX_PIXELS_DEF  = 131072;
  localparam int unsigned PIXEL_COUNT_RST = 88704;

  // Pixel count register and write position
  localparam int unsigned CFG_W = 18;
  // Wide enough to follow the position even if the pixel count shrinks mid-chunk
  localparam int unsigned WP_W  = 32;

  // Stream payload widths
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 16;

  // Request types
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Result kinds
  localparam logic RES_STATUS = 1'b0;
  localparam logic RES_PIXEL  = 1'b1;

  // Frame kinds
  localparam logic [1:0] KIND_RAW = 2'd0;
  localparam logic [1:0] KIND_KEY = 2'd1;
  localparam logic [1:0] KIND_XOR = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  // Chunk status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_KIND = 3'd1;
  localparam logic [2:0] ST_RUN_PAST = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_LIT_CUT  = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;
  localparam logic [2:0] ST_RAW_SIZE = 3'd6;

  // Code byte fields
  localparam logic [7:0] CODE_CNT_MASK = 8'd127;
  localparam logic [7:0] CODE_RUN_FLAG = 8'd128;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FILL,
    S_XRD,
    S_XWR,
    S_STAT
  } state_e;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_VALUE,
    PH_LITERAL
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [2:0] status;
    logic [7:0] pixel;
  } res_t;

endpackage

/* hdl/rfdx_ram.sv */
module rfdx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rfdx_ctrl.sv */
module rfdx_ctrl
  import rfdx_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
  localparam int unsigned ADDR_W    = $clog2(MAX_PIXELS),
  localparam int unsigned POS_W     = $clog2(MAX_PIXELS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic [1:0]        frame_kind_i,
  input  logic              last_byte_i,
  input  logic [16:0]       read_index_i,
  input  logic [POS_W-1:0]  lim_i,
  input  logic              out_free_i,
  output res_t              res_o,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_raddr_o,
  input  logic [7:0]        ram_rdata_i
);

  localparam logic [WP_W-1:0] MAX_W = WP_W'(MAX_PIXELS);

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d, phase_e_s;
  logic [WP_W-1:0] wp_q, wp_d, wp_e;
  logic [7:0]      rem_q, rem_d, rem_e, rem_dec;
  logic [1:0]      kind_q, kind_d, kind_e;
  logic [2:0]      err_q, err_d, err_e, fin_st;
  logic            started_q, started_d;
  logic [7:0]      left_q, left_d;
  logic [7:0]      val_q, val_d;
  logic            last_q, last_d;
  logic            oor_q, oor_d;

  logic [7:0]      cnt8;
  logic [WP_W-1:0] lim_w;
  logic            run_err, raw_full, engine;
  state_e          done_st;

  assign lim_w    = WP_W'(lim_i);
  assign cnt8     = (data_byte_i & CODE_CNT_MASK) + 8'd1;
  assign run_err  = (wp_e <= lim_w) &&
                    (({1'b0, wp_e} + (WP_W + 1)'(cnt8)) > {1'b0, lim_w});
  assign raw_full = (wp_e >= lim_w);
  assign rem_dec  = rem_e - 8'd1;
  assign done_st  = last_q ? S_STAT : S_IDLE;
  assign in_ready_o = (state_q == S_IDLE);

  // A new chunk starts from clean parse state on its first byte
  always_comb begin
    if (!started_q) begin
      kind_e    = frame_kind_i;
      wp_e      = '0;
      phase_e_s = PH_CODE;
      rem_e     = '0;
      err_e     = (frame_kind_i == KIND_BAD) ? ST_BAD_KIND : ST_OK;
    end else begin
      kind_e    = kind_q;
      wp_e      = wp_q;
      phase_e_s = phase_q;
      rem_e     = rem_q;
      err_e     = err_q;
    end
  end

  always_comb begin
    fin_st = err_q;
    if (err_q == ST_OK && wp_q != lim_w) begin
      fin_st = (kind_q == KIND_RAW) ? ST_RAW_SIZE : ST_SHORT;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    wp_d        = wp_q;
    rem_d       = rem_q;
    kind_d      = kind_q;
    err_d       = err_q;
    started_d   = started_q;
    left_d      = left_q;
    val_d       = val_q;
    last_d      = last_q;
    oor_d       = oor_q;
    engine      = 1'b0;
    res_o       = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wp_q[ADDR_W-1:0];
    ram_wdata_o = val_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = wp_q[ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_READ) begin
            oor_d       = ({{(WP_W - 17){1'b0}}, read_index_i} >= MAX_W);
            ram_re_o    = !oor_d;
            ram_raddr_o = ADDR_W'(read_index_i);
            state_d     = S_READ;
          end else begin
            kind_d    = kind_e;
            wp_d      = wp_e;
            phase_d   = phase_e_s;
            rem_d     = rem_e;
            err_d     = err_e;
            started_d = 1'b1;
            last_d    = last_byte_i;
            if (err_e == ST_OK) begin
              if (kind_e == KIND_RAW) begin
                if (raw_full) begin
                  err_d = ST_RAW_SIZE;
                end else begin
                  ram_we_o    = (wp_e < MAX_W);
                  ram_waddr_o = wp_e[ADDR_W-1:0];
                  ram_wdata_o = data_byte_i;
                  wp_d        = wp_e + WP_W'(1);
                end
              end else begin
                case (phase_e_s)
                  PH_CODE: begin
                    if (run_err) begin
                      err_d = ST_RUN_PAST;
                    end else begin
                      rem_d = cnt8;
                      if ((data_byte_i & CODE_RUN_FLAG) != 8'd0) begin
                        phase_d = PH_VALUE;
                        if (last_byte_i) err_d = ST_MISSING;
                      end else begin
                        phase_d = PH_LITERAL;
                        if (last_byte_i) err_d = ST_LIT_CUT;
                      end
                    end
                  end
                  PH_VALUE: begin
                    left_d  = rem_e;
                    val_d   = data_byte_i;
                    rem_d   = '0;
                    phase_d = PH_CODE;
                    engine  = 1'b1;
                  end
                  PH_LITERAL: begin
                    rem_d = rem_dec;
                    if (rem_dec == 8'd0) begin
                      phase_d = PH_CODE;
                    end else if (last_byte_i) begin
                      err_d = ST_LIT_CUT;
                    end
                    if (kind_e == KIND_XOR) begin
                      left_d = 8'd1;
                      val_d  = data_byte_i;
                      engine = 1'b1;
                    end else begin
                      ram_we_o    = (wp_e < MAX_W);
                      ram_waddr_o = wp_e[ADDR_W-1:0];
                      ram_wdata_o = data_byte_i;
                      wp_d        = wp_e + WP_W'(1);
                    end
                  end
                  default: ;
                endcase
              end
            end
            if (engine) begin
              state_d = (kind_e == KIND_XOR) ? S_XRD : S_FILL;
            end else begin
              state_d = last_byte_i ? S_STAT : S_IDLE;
            end
          end
        end
      end
      S_FILL: begin
        ram_we_o = (wp_q < MAX_W);
        wp_d     = wp_q + WP_W'(1);
        left_d   = left_q - 8'd1;
        if (left_q == 8'd1) state_d = done_st;
      end
      S_XRD: begin
        ram_re_o = (wp_q < MAX_W);
        state_d  = S_XWR;
      end
      S_XWR: begin
        ram_we_o    = (wp_q < MAX_W);
        ram_wdata_o = ram_rdata_i ^ val_q;
        wp_d        = wp_q + WP_W'(1);
        left_d      = left_q - 8'd1;
        state_d     = (left_q == 8'd1) ? done_st : S_XRD;
      end
      S_READ: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = RES_PIXEL;
          res_o.pixel = oor_q ? 8'd0 : ram_rdata_i;
          state_d     = S_IDLE;
        end
      end
      S_STAT: begin
        if (out_free_i) begin
          res_o.valid  = 1'b1;
          res_o.kind   = RES_STATUS;
          res_o.status = fin_st;
          err_d        = fin_st;
          started_d    = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_CODE;
      wp_q      <= '0;
      rem_q     <= '0;
      kind_q    <= KIND_RAW;
      err_q     <= ST_OK;
      started_q <= 1'b0;
      left_q    <= '0;
      last_q    <= 1'b0;
      oor_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      wp_q      <= wp_d;
      rem_q     <= rem_d;
      kind_q    <= kind_d;
      err_q     <= err_d;
      started_q <= started_d;
      left_q    <= left_d;
      last_q    <= last_d;
      oor_q     <= oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

/* hdl/rle_frame_decoder_xor_delta_unit.sv */
// A pixel read goes through the frame store read register, then into the output register
// from S_READ once that is free; a last byte's status waits in S_STAT the same way. No item
// is taken while a run is expanded: a key frame run writes in S_FILL, a delta run or literal
// does one read-modify-write per pixel on the single store port pair via S_XRD and S_XWR.
// Reset clears all control state; frame store contents stay undefined until written.
module rle_frame_decoder_xor_delta_unit
  import rfdx_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel count register
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input items
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // [7:0] data_byte, [24:8] read_index
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,  // [0] req_type, [2:1] frame_kind
  input  logic                 s_axis_tlast_i,  // last_byte
  // result items
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // [2:0] status, [10:3] pixel_value
  output logic                 m_axis_tuser_o   // result_kind
);

  localparam int unsigned ADDR_W  = $clog2(MAX_PIXELS);
  localparam int unsigned POS_W   = $clog2(MAX_PIXELS + 1);
  localparam int unsigned LIM_RST = (PIXEL_COUNT_RST > MAX_PIXELS) ? MAX_PIXELS
                                                                   : PIXEL_COUNT_RST;

  // Frame limit: the pixel count saturated to the store depth, worked out at write time
  logic [POS_W-1:0] lim_q;
  logic [POS_W-1:0] lim_d;

  always_comb begin
    if (32'(cfg_wdata_i) > 32'(MAX_PIXELS)) begin
      lim_d = POS_W'(MAX_PIXELS);
    end else begin
      lim_d = POS_W'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= POS_W'(LIM_RST);
    end else if (cfg_we_i) begin
      lim_q <= lim_d;
    end
  end

  // Frame store port wiring
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  res_t res;
  logic out_free;
  logic in_acc;

  // Output register: hold a finished item until the far side takes it
  logic       out_valid_q;
  logic       out_kind_q;
  logic [2:0] out_status_q;
  logic [7:0] out_pixel_q;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  rfdx_ctrl #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .req_type_i   (s_axis_tuser_i[0]),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .frame_kind_i (s_axis_tuser_i[2:1]),
    .last_byte_i  (s_axis_tlast_i),
    .read_index_i (s_axis_tdata_i[24:8]),
    .lim_i        (lim_q),
    .out_free_i   (out_free),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  rfdx_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PIXELS)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the payload only when the controller hands over a new item
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_kind_q   <= res.kind;
      out_status_q <= res.status;
      out_pixel_q  <= res.pixel;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - 11){1'b0}}, out_pixel_q, out_status_q};

`ifndef SYNTH
  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || m_axis_tready_i))
    else $error("result handed over while output register still full");

  a_lim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lim_q <= POS_W'(MAX_PIXELS))
    else $error("frame limit above store depth");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && !in_acc) |-> !s_axis_tready_o)
    else $error("frame store written by engine while input is open");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i[0]) |=> !s_axis_tready_o)
    else $error("input reopened before pixel read completed");
`endif

endmodule
